/* src/srpq_pkg.sv */
package srpq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PRIO_W = 7;
    localparam int CHAR_W = 8;
    localparam int STATUS_W = 2;

    localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
    localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(100);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [CHAR_W-1:0] chr;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

/* src/srpq_in_if.sv */
interface srpq_in_if;
    logic valid;
    logic ready;
    logic mode;
    logic [srpq_pkg::PRIO_W-1:0] new_prio;
    logic [srpq_pkg::CHAR_W-1:0] new_char;

    modport source (output valid, output mode, output new_prio, output new_char, input ready);
    modport sink (input valid, input mode, input new_prio, input new_char, output ready);
endinterface

/* src/srpq_out_if.sv */
interface srpq_out_if;
    logic valid;
    logic ready;
    logic out_valid;
    logic [srpq_pkg::PRIO_W-1:0] out_prio;
    logic [srpq_pkg::CHAR_W-1:0] out_char;
    logic [srpq_pkg::STATUS_W-1:0] status;
    logic [srpq_pkg::CNT_W-1:0] entry_count;
    logic now_empty;
    logic now_full;

    modport source (
        output valid, output out_valid, output out_prio, output out_char,
        output status, output entry_count, output now_empty, output now_full,
        input ready
    );
    modport sink (
        input valid, input out_valid, input out_prio, input out_char,
        input status, input entry_count, input now_empty, input now_full,
        output ready
    );
endinterface

/* src/srpq_cfg_if.sv */
interface srpq_cfg_if;
    logic valid;
    logic ready;
    logic [srpq_pkg::CNT_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

/* src/srpq_cell.sv */
module srpq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  srpq_pkg::cell_ctl_t ctl,
    input  srpq_pkg::entry_t   left_entry,
    input  logic               left_valid,
    input  logic               left_gt,
    input  srpq_pkg::entry_t   right_entry,
    input  logic               right_valid,
    output srpq_pkg::entry_t   entry,
    output logic               valid,
    output logic               gt
);
    import srpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // empty cells count as larger so a new word lands at the tail
    assign gt = !valid_reg || (entry_reg.prio > ctl.new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
                entry_next = entry_reg;
            end
            OP_PUSH:
            begin
                valid_next = valid_reg || left_valid;
                if (gt)
                begin
                    entry_next = left_gt ? left_entry : ctl.new_entry;
                end
            end
            OP_POP:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
endmodule

/* src/sorted_ring_priority_queue.sv */
// sorted priority queue of (priority, character) entries, smallest priority
// value leaves first, equal priorities leave in arrival order
// in_ch: one word per request, mode 0 inserts new_prio/new_char, mode 1
// removes the head entry; out_ch: one word per request with the removed
// entry (if any), status, entry count and empty/full flags
// cfg_ch: writes the capacity in use (0 taken as 1, above 16 as 16) and
// empties the queue; always ready, write only while no request is pending
// entries sit in a row of 16 cells ordered head first; an insert compares
// against all cells at once and shifts the larger ones one cell back, a
// removal shifts the whole row one cell forward, all cells at once
// latency: the result word is registered, valid the cycle after accept
// throughput: one request per cycle while out_ch is taken each cycle
// full inserts and empty removals are refused with an error status
// reset leaves the queue empty with capacity 16, no clearing pass
// when out_ch stalls the result word holds and in_ch ready drops
module sorted_ring_priority_queue (
    input  logic            clk,
    input  logic            rst_n,
    srpq_in_if.sink         in_ch,
    srpq_out_if.source      out_ch,
    srpq_cfg_if.sink        cfg_ch
);
    import srpq_pkg::*;

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                ovalid_reg;
    logic                ovalid_next;
    logic                oout_valid_reg;
    logic                oout_valid_next;
    logic [PRIO_W-1:0]   oprio_reg;
    logic [PRIO_W-1:0]   oprio_next;
    logic [CHAR_W-1:0]   ochar_reg;
    logic [CHAR_W-1:0]   ochar_next;
    logic [STATUS_W-1:0] ostatus_reg;
    logic [STATUS_W-1:0] ostatus_next;
    logic [CNT_W-1:0]    ocount_reg;
    logic [CNT_W-1:0]    ocount_next;
    logic                oempty_reg;
    logic                oempty_next;
    logic                ofull_reg;
    logic                ofull_next;

    logic              accept;
    logic              cfg_write;
    logic              full;
    logic              push_ok;
    logic              pop_ok;
    logic [PRIO_W-1:0] prio_clamped;
    cell_ctl_t         ctl;

    entry_t cell_entry [DEPTH];
    logic   cell_valid [DEPTH];
    logic   cell_gt [DEPTH];

    assign in_ch.ready = !ovalid_reg || out_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign accept = in_ch.valid && in_ch.ready;
    assign cfg_write = cfg_ch.valid;

    assign full = (count_reg == cap_reg);
    assign push_ok = accept && (in_ch.mode == MODE_INSERT) && !full;
    assign pop_ok = accept && (in_ch.mode == MODE_REMOVE) && (count_reg != '0);

    always_comb
    begin
        if (in_ch.new_prio < PRIO_MIN)
        begin
            prio_clamped = PRIO_MIN;
        end
        else if (in_ch.new_prio > PRIO_MAX)
        begin
            prio_clamped = PRIO_MAX;
        end
        else
        begin
            prio_clamped = in_ch.new_prio;
        end
    end

    always_comb
    begin
        ctl.new_entry.prio = prio_clamped;
        ctl.new_entry.chr = in_ch.new_char;
        if (cfg_write)
        begin
            ctl.op = OP_CLEAR;
        end
        else if (push_ok)
        begin
            ctl.op = OP_PUSH;
        end
        else if (pop_ok)
        begin
            ctl.op = OP_POP;
        end
        else
        begin
            ctl.op = OP_HOLD;
        end
    end

    always_comb
    begin
        cap_next = cap_reg;
        count_next = count_reg;
        if (cfg_write)
        begin
            if (cfg_ch.capacity == '0)
            begin
                cap_next = CNT_W'(1);
            end
            else if (cfg_ch.capacity > CNT_W'(DEPTH))
            begin
                cap_next = CNT_W'(DEPTH);
            end
            else
            begin
                cap_next = cfg_ch.capacity;
            end
            count_next = '0;
        end
        else if (push_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        oout_valid_next = oout_valid_reg;
        oprio_next = oprio_reg;
        ochar_next = ochar_reg;
        ostatus_next = ostatus_reg;
        ocount_next = ocount_reg;
        oempty_next = oempty_reg;
        ofull_next = ofull_reg;
        if (accept)
        begin
            ovalid_next = 1'b1;
            oout_valid_next = pop_ok;
            oprio_next = pop_ok ? cell_entry[0].prio : '0;
            ochar_next = pop_ok ? cell_entry[0].chr : '0;
            if (in_ch.mode == MODE_INSERT)
            begin
                ostatus_next = full ? STATUS_FULL : STATUS_OK;
            end
            else
            begin
                ostatus_next = pop_ok ? STATUS_OK : STATUS_EMPTY;
            end
            ocount_next = count_next;
            oempty_next = (count_next == '0);
            ofull_next = (count_next == cap_reg);
        end
        else if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(DEPTH);
            count_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cap_reg <= cap_next;
            count_reg <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oout_valid_reg <= oout_valid_next;
        oprio_reg <= oprio_next;
        ochar_reg <= ochar_next;
        ostatus_reg <= ostatus_next;
        ocount_reg <= ocount_next;
        oempty_reg <= oempty_next;
        ofull_reg <= ofull_next;
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            entry_t left_entry;
            logic   left_valid;
            logic   left_gt;
            entry_t right_entry;
            logic   right_valid;

            if (k == 0)
            begin : g_head
                assign left_entry = '0;
                assign left_valid = 1'b1;
                assign left_gt = 1'b0;
            end
            else
            begin : g_mid
                assign left_entry = cell_entry[k-1];
                assign left_valid = cell_valid[k-1];
                assign left_gt = cell_gt[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_body
                assign right_entry = cell_entry[k+1];
                assign right_valid = cell_valid[k+1];
            end

            srpq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_entry  (left_entry),
                .left_valid  (left_valid),
                .left_gt     (left_gt),
                .right_entry (right_entry),
                .right_valid (right_valid),
                .entry       (cell_entry[k]),
                .valid       (cell_valid[k]),
                .gt          (cell_gt[k])
            );
        end
    endgenerate

    assign out_ch.valid = ovalid_reg;
    assign out_ch.out_valid = oout_valid_reg;
    assign out_ch.out_prio = oprio_reg;
    assign out_ch.out_char = ochar_reg;
    assign out_ch.status = ostatus_reg;
    assign out_ch.entry_count = ocount_reg;
    assign out_ch.now_empty = oempty_reg;
    assign out_ch.now_full = ofull_reg;
endmodule
